@@ rtl/core/mkt_pkg.sv @@
// Package for the MRU key tracker.
// Holds the sizes, command codes and the per-cell control word.
// Used by mkt_cell and mru_key_tracker; depends on nothing.
package mkt_pkg;

	// Number of cells in the chain and the key width.
	localparam int DEPTH = 16;
	localparam int KEY_W = 32;

	// Count holds 0..DEPTH; an index addresses one cell.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Width of the capacity register.
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Command codes.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// Control word broadcast to every cell.
	typedef struct packed {
		logic is_insert;
		logic is_remove;
		logic drop;
	} cell_ctl_t;

endpackage

@@ rtl/core/mkt_cell.sv @@
// One cell of the MRU chain: holds one key and compares it with the command key.
// Depends on mkt_pkg for the key width and the control word.
// Takes its new key from the command key, itself, its upper neighbor or the one after it.
module mkt_cell
	import mkt_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [KEY_W-1:0] cmd_key,
	input  logic             valid,
	input  logic             append,
	input  logic [KEY_W-1:0] next_key,
	input  logic [KEY_W-1:0] next2_key,
	input  logic             hit_in,
	input  logic             hit_next,
	output logic             hit_out,
	output logic [KEY_W-1:0] key_q
);

	logic       match;
	logic [1:0] shift;

	// Compare against the command key; the hit ripples up toward the newest cell.
	assign match   = valid && (key_q == cmd_key) && (ctl.is_insert || ctl.is_remove);
	assign hit_out = hit_in || match;

	// Every cell at or above the removed slot moves down one more place. When the
	// oldest key is dropped too, the cell just below the removed slot skips over it,
	// so the upper neighbor's hit decides the extra place.
	assign shift = {1'b0, ctl.drop} + {1'b0, (ctl.drop ? hit_next : hit_out)};

	// Key storage: load the new key at the append slot, otherwise close gaps.
	always_ff @(posedge clk) begin
		if (ctl.is_insert && append) begin
			key_q <= cmd_key;
		end else if (ctl.is_insert || ctl.is_remove) begin
			case (shift)
				2'd0:    key_q <= key_q;
				2'd1:    key_q <= next_key;
				2'd2:    key_q <= next2_key;
				default: key_q <= key_q;
			endcase
		end
	end

endmodule

@@ rtl/core/mru_key_tracker.sv @@
// Top level of the MRU key tracker: a chain of key cells plus count and read logic.
// Depends on mkt_pkg and mkt_cell.
//
// Usage: a command word (command, key) is taken at a rising edge where start is
// high and busy is low. Insert, remove and clear take effect at that edge; all
// cells compare in parallel and shift by zero, one or two places toward the
// oldest slot, so these commands can be issued back to back.
// A read streams the list newest first, one result word per cycle, each shown
// for exactly one cycle with result_strobe high; last marks the final word.
// The sequencer loads the read pointer when the read is accepted, and each word
// is then registered from the cell it points at; busy stays high until the
// final word has been registered. An empty list gives one word with entry_valid
// low and last high, shown in the cycle right after the accepting edge, without
// busy. Capacity is written through capacity_we / capacity_wdata; the user must
// write it only while idle, the block itself does not enforce this. Reset empties
// the list and sets capacity to 16. The receiver cannot stall: every result word
// must be taken in the cycle it is shown.
module mru_key_tracker
	import mkt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       command,
	input  logic [KEY_W-1:0] key,
	input  logic             capacity_we,
	input  logic [CAP_W-1:0] capacity_wdata,
	output logic             result_strobe,
	output logic [KEY_W-1:0] entry_key,
	output logic             entry_valid,
	output logic             last
);

	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	logic             reading_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic             strobe_q;
	logic [KEY_W-1:0] entry_key_q;
	logic             entry_valid_q;
	logic             last_q;

	logic             accept;
	cmd_t             cmd;
	cell_ctl_t        ctl;
	logic [CNT_W-1:0] cap_eff;
	logic             any_match;
	logic [CNT_W-1:0] count_rm;
	logic [CNT_W-1:0] count_kept;
	logic             drop;

	logic [KEY_W-1:0] cell_key  [DEPTH];
	logic [DEPTH:0]   hit_chain;
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] cell_append;

	assign accept = start && !busy;
	assign cmd    = cmd_t'(command);
	assign busy   = reading_q;

	// Effective capacity: zero counts as one, anything above the depth saturates.
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (CNT_W'(capacity_q) > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
	end

	// Count after removing a match, then after dropping the oldest on a full insert.
	assign any_match  = hit_chain[DEPTH];
	assign count_rm   = count_q - CNT_W'(any_match);
	assign drop       = ctl.is_insert && (count_rm >= cap_eff);
	assign count_kept = count_rm - CNT_W'(drop);

	// Control word for the whole chain.
	assign ctl.is_insert = accept && (cmd == CMD_INSERT);
	assign ctl.is_remove = accept && (cmd == CMD_REMOVE);
	assign ctl.drop      = drop;

	// Chain of cells, slot 0 holds the oldest key.
	assign hit_chain[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] nk;
		logic [KEY_W-1:0] nk2;
		logic             hn;

		assign cell_valid[i]  = (CNT_W'(i) < count_q);
		assign cell_append[i] = (CNT_W'(i) == count_kept);

		if (i + 1 < DEPTH) begin : g_n1
			assign nk = cell_key[i+1];
			assign hn = hit_chain[i+2];
		end else begin : g_n1_end
			assign nk = '0;
			assign hn = hit_chain[DEPTH];
		end
		if (i + 2 < DEPTH) begin : g_n2
			assign nk2 = cell_key[i+2];
		end else begin : g_n2_end
			assign nk2 = '0;
		end

		mkt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cmd_key   (key),
			.valid     (cell_valid[i]),
			.append    (cell_append[i]),
			.next_key  (nk),
			.next2_key (nk2),
			.hit_in    (hit_chain[i]),
			.hit_next  (hn),
			.hit_out   (hit_chain[i+1]),
			.key_q     (cell_key[i])
		);
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			case (cmd)
				CMD_INSERT: count_q <= count_kept + CNT_W'(1);
				CMD_REMOVE: count_q <= count_rm;
				CMD_CLEAR:  count_q <= '0;
				default:    count_q <= count_q;
			endcase
		end
	end

	// Read sequencer: walks the pointer from the newest entry down to slot 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q <= 1'b0;
			rd_ptr_q  <= '0;
		end else if (reading_q) begin
			if (rd_ptr_q == '0) begin
				reading_q <= 1'b0;
			end else begin
				rd_ptr_q <= rd_ptr_q - IDX_W'(1);
			end
		end else if (accept && (cmd == CMD_READ) && (count_q != '0)) begin
			reading_q <= 1'b1;
			rd_ptr_q  <= IDX_W'(count_q - CNT_W'(1));
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= reading_q || (accept && (cmd == CMD_READ) && (count_q == '0));
		end
	end

	// Result word registers.
	always_ff @(posedge clk) begin
		if (reading_q) begin
			entry_key_q   <= cell_key[rd_ptr_q];
			entry_valid_q <= 1'b1;
			last_q        <= (rd_ptr_q == '0);
		end else begin
			entry_key_q   <= '0;
			entry_valid_q <= 1'b0;
			last_q        <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign entry_key     = entry_key_q;
	assign entry_valid   = entry_valid_q;
	assign last          = last_q;

	// While a read runs, the read pointer addresses a live entry.
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		reading_q |-> (CNT_W'(rd_ptr_q) < count_q))
		else $error("read pointer beyond entry count");

	// The count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// An empty-list word is always the final word.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !entry_valid_q) |-> last_q)
		else $error("empty result word not marked last");

	// After an insert the list holds at least one entry.
	a_insert_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.is_insert |=> (count_q != '0))
		else $error("list empty after insert");

	// At most one cell matches (no duplicates); this checks only hits <= DEPTH.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.is_insert || ctl.is_remove) |-> ($countones(hit_chain) <= DEPTH))
		else $error("hit chain corrupt");

endmodule

@@ verif/mru_key_tracker_test.sv @@
// Self-checking testbench for mru_key_tracker, the most-recently-used key list.
// A predictor of its own tracks the list and the capacity and checks each read word.
// Depends on mkt_pkg and the mru_key_tracker RTL only.
module mru_key_tracker_test
	import mkt_pkg::*;
();

	localparam int unsigned RUN_LIMIT = 2_000_000;
	localparam int unsigned DRAIN_PAUSE = DEPTH + 4;
	localparam int POOL_SIZE = 24;

	// One read word as the block should present it.
	typedef struct {
		logic [KEY_W-1:0] key;
		logic             valid;
		logic             is_last;
	} entry_word_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       command;
	logic [KEY_W-1:0] key;
	logic             capacity_we;
	logic [CAP_W-1:0] capacity_wdata;
	logic             result_strobe;
	logic [KEY_W-1:0] entry_key;
	logic             entry_valid;
	logic             last;

	// Predicted list: slot 0 holds the oldest key.
	logic [KEY_W-1:0] mru_slots [DEPTH];
	int unsigned      mru_count;
	logic [CAP_W-1:0] capacity_setting;
	entry_word_t      pending_words [$];

	int unsigned mismatch_count;
	int unsigned words_sent;
	int unsigned reads_sent;
	int unsigned words_checked;
	int unsigned evictions;
	int unsigned peak_count;

	mru_key_tracker DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.key            (key),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.result_strobe  (result_strobe),
		.entry_key      (entry_key),
		.entry_valid    (entry_valid),
		.last           (last)
	);

	// Free-running clock, period 8.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Capacity as the block applies it: zero acts as one, the top saturates at DEPTH.
	function automatic int unsigned applied_capacity();
		if (capacity_setting == '0)
			return 1;
		if (capacity_setting > DEPTH)
			return DEPTH;
		return capacity_setting;
	endfunction

	// Delete the slot at pos and close the gap toward the oldest end.
	function automatic void drop_slot(int unsigned pos);
		if (pos >= mru_count)
			return;
		for (int unsigned i = pos; i + 1 < mru_count; i++)
			mru_slots[i] = mru_slots[i + 1];
		mru_count--;
	endfunction

	function automatic void remove_matching(logic [KEY_W-1:0] k);
		for (int unsigned i = 0; i < mru_count; i++) begin
			if (mru_slots[i] == k) begin
				drop_slot(i);
				return;
			end
		end
	endfunction

	// Update the predicted list for one accepted word and queue any read words.
	function automatic void track_command(cmd_t op, logic [KEY_W-1:0] k);
		entry_word_t w;
		case (op)
			CMD_INSERT: begin
				remove_matching(k);
				if (mru_count >= applied_capacity()) begin
					drop_slot(0);
					evictions++;
				end
				if (mru_count < DEPTH) begin
					mru_slots[mru_count] = k;
					mru_count++;
				end
				if (mru_count > peak_count)
					peak_count = mru_count;
			end
			CMD_REMOVE: begin
				remove_matching(k);
			end
			CMD_CLEAR: begin
				mru_count = 0;
			end
			default: begin
				if (mru_count == 0) begin
					w.key = '0;
					w.valid = 1'b0;
					w.is_last = 1'b1;
					pending_words = {pending_words, w};
				end else begin
					for (int unsigned i = mru_count; i > 0; i--) begin
						w.key = mru_slots[i - 1];
						w.valid = 1'b1;
						w.is_last = (i == 1);
						pending_words = {pending_words, w};
					end
				end
			end
		endcase
	endfunction

	// Check every read word against the oldest prediction.
	always @(posedge clk) begin
		entry_word_t w;
		if (arst_n && result_strobe !== 1'b0) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected read word: key %h valid %b last %b",
					$time, entry_key, entry_valid, last);
				mismatch_count++;
			end else begin
				w = pending_words[0];
				pending_words.delete(0);
				words_checked++;
				if (entry_key !== w.key) begin
					$display("%0t: entry_key expected %h, got %h", $time, w.key, entry_key);
					mismatch_count++;
				end
				if (entry_valid !== w.valid) begin
					$display("%0t: entry_valid expected %b, got %b",
						$time, w.valid, entry_valid);
					mismatch_count++;
				end
				if (last !== w.is_last) begin
					$display("%0t: last expected %b, got %b", $time, w.is_last, last);
					mismatch_count++;
				end
			end
		end
	end

	// Present one command word and hold it until the block takes it.
	task automatic send_word(input cmd_t op, input logic [KEY_W-1:0] k);
		@(negedge clk);
		start <= 1'b1;
		command <= op;
		key <= k;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		track_command(op, k);
		words_sent++;
		if (op == CMD_READ)
			reads_sent++;
	endtask

	// Leave start low for a number of cycles with noise on the command fields.
	task automatic idle_for(input int unsigned cycles);
		if (cycles == 0)
			return;
		@(negedge clk);
		start <= 1'b0;
		command <= 2'($urandom);
		key <= $urandom;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Stop sending until every predicted word has arrived, then let the block settle.
	task automatic wait_for_drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE)
			@(negedge clk);
	endtask

	// Capacity is written only once the block has gone idle.
	task automatic set_capacity(input logic [CAP_W-1:0] value);
		wait_for_drain();
		@(negedge clk);
		capacity_we <= 1'b1;
		capacity_wdata <= value;
		@(posedge clk);
		capacity_setting = value;
		@(negedge clk);
		capacity_we <= 1'b0;
		capacity_wdata <= 5'($urandom);
	endtask

	// Reads, removes and clears on an empty list.
	task automatic test_empty_list();
		send_word(CMD_READ, $urandom);
		send_word(CMD_REMOVE, 32'h0000_0005);
		send_word(CMD_CLEAR, $urandom);
		send_word(CMD_READ, $urandom);
	endtask

	// Key extremes, and a repeated insert moving a key to the newest place.
	task automatic test_key_extremes();
		send_word(CMD_INSERT, '0);
		send_word(CMD_INSERT, '1);
		send_word(CMD_INSERT, '0);
		send_word(CMD_READ, $urandom);
	endtask

	// Remove of a present key closes the gap; remove of an absent key does nothing.
	task automatic test_remove();
		send_word(CMD_INSERT, 32'hA5A5_0001);
		send_word(CMD_REMOVE, '1);
		idle_for(3);
		send_word(CMD_REMOVE, 32'h0000_1234);
		send_word(CMD_READ, $urandom);
	endtask

	// Small capacities, including zero which acts as one.
	task automatic test_small_capacity();
		set_capacity(5'd2);
		send_word(CMD_INSERT, 32'h0000_0001);
		send_word(CMD_INSERT, 32'h0000_0002);
		send_word(CMD_INSERT, 32'h0000_0003);
		send_word(CMD_READ, $urandom);
		set_capacity(5'd0);
		send_word(CMD_INSERT, 32'h0000_0009);
		send_word(CMD_READ, $urandom);
	endtask

	// Capacity lowered below the count: an insert drops only the one oldest key.
	task automatic test_capacity_lowered();
		set_capacity(5'd16);
		send_word(CMD_INSERT, 32'h1000_0001);
		send_word(CMD_INSERT, 32'h1000_0002);
		send_word(CMD_INSERT, 32'h1000_0003);
		set_capacity(5'd2);
		send_word(CMD_INSERT, 32'h1000_0004);
		send_word(CMD_READ, $urandom);
		send_word(CMD_CLEAR, $urandom);
		send_word(CMD_READ, $urandom);
	endtask

	// Capacity above DEPTH saturates; the random part runs a phase with capacity 31 as well.
	task automatic test_capacity_saturated();
		set_capacity(5'd31);
		send_word(CMD_INSERT, 32'h5A5A_5A5A);
		send_word(CMD_READ, $urandom);
	endtask

	// Random traffic in bursts, one capacity per phase, keys mostly from a small pool.
	task automatic test_random_traffic();
		logic [KEY_W-1:0] pool [POOL_SIZE];
		logic [CAP_W-1:0] cap_value;
		logic [KEY_W-1:0] k;
		cmd_t             op;
		int unsigned      burst_left;
		int unsigned      insert_pct;
		int unsigned      r;
		burst_left = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: cap_value = 5'd31;
				1: cap_value = 5'd3;
				2: cap_value = 5'd16;
				3: cap_value = 5'd0;
				4: cap_value = 5'($urandom_range(1, 31));
				default: cap_value = 5'd17;
			endcase
			set_capacity(cap_value);
			insert_pct = (phase == 0 || phase == 5) ? 80 : 50;
			for (int i = 0; i < POOL_SIZE; i++)
				pool[i] = $urandom;
			pool[0] = '0;
			pool[1] = '1;
			for (int n = 0; n < 37; n++) begin
				if (burst_left == 0) begin
					idle_for($urandom_range(0, 6));
					burst_left = ($urandom_range(0, 3) == 0) ?
						$urandom_range(20, 40) : $urandom_range(1, 10);
				end
				burst_left--;
				r = $urandom_range(0, 99);
				if (r < insert_pct)
					op = CMD_INSERT;
				else if (r < insert_pct + (100 - insert_pct) / 2)
					op = CMD_REMOVE;
				else if (r < 97)
					op = CMD_READ;
				else
					op = CMD_CLEAR;
				k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
					: $urandom;
				send_word(op, k);
				// Now and then hold off until the read words have all come back.
				if (op == CMD_READ && $urandom_range(0, 11) == 0)
					wait_for_drain();
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_INSERT;
		key <= '0;
		capacity_we <= 1'b0;
		capacity_wdata <= '0;
		mismatch_count = 0;
		words_sent = 0;
		reads_sent = 0;
		words_checked = 0;
		evictions = 0;
		peak_count = 0;
		mru_count = 0;
		capacity_setting = CAP_RESET;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_key_extremes();
		test_remove();
		test_small_capacity();
		test_capacity_lowered();
		test_capacity_saturated();
		test_random_traffic();

		wait_for_drain();
		repeat (DRAIN_PAUSE)
			@(posedge clk);
		$display("Sent %0d command words (%0d reads) over capacities 0 to 31.",
			words_sent, reads_sent);
		$display("Checked %0d read words; %0d oldest-key drops; list reached %0d keys.",
			words_checked, evictions, peak_count);
		if (mismatch_count == 0)
			$display("mru_key_tracker_test OK");
		else
			$display("mru_key_tracker_test NOT OK");
		$finish;
	end

	// Watchdog in case the block stops taking words or stops answering.
	initial begin
		#RUN_LIMIT;
		$display("Timed out with %0d read words still expected.", pending_words.size());
		$display("mru_key_tracker_test NOT OK");
		$finish;
	end

endmodule
